// ----- design/ncrd_pkg.sv -----
`default_nettype none
package ncrd_pkg;

	typedef enum logic [2:0] {
		PH_INITIAL   = 3'd0,
		PH_NUMBER    = 3'd1,
		PH_MAYBE_HEX = 3'd2,
		PH_HEX       = 3'd3,
		PH_DECIMAL   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_DECODED = 2'd0,
		ST_NOT_REF = 2'd1,
		ST_NAMED   = 2'd2,
		ST_NEED    = 2'd3
	} status_t;

	localparam int unsigned CharW = 21;
	localparam int unsigned CodeW = 32;
	localparam int unsigned StopW = 7;

	localparam logic [CharW-1:0] MaxCode = 21'h10FFFF;

	localparam logic [CharW-1:0] ChTab   = 21'h09;
	localparam logic [CharW-1:0] ChLf    = 21'h0A;
	localparam logic [CharW-1:0] ChFf    = 21'h0C;
	localparam logic [CharW-1:0] ChSpace = 21'h20;
	localparam logic [CharW-1:0] ChLt    = 21'h3C;
	localparam logic [CharW-1:0] ChAmp   = 21'h26;
	localparam logic [CharW-1:0] ChHash  = 21'h23;
	localparam logic [CharW-1:0] ChSemi  = 21'h3B;
	localparam logic [CharW-1:0] ChX     = 21'h78;
	localparam logic [CharW-1:0] ChXUp   = 21'h58;

	function automatic logic is_dec(input logic [CharW-1:0] c);
		return c >= 21'h30 && c <= 21'h39;
	endfunction

	function automatic logic is_hex_alpha(input logic [CharW-1:0] c);
		return (c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46);
	endfunction

	function automatic logic is_alpha(input logic [CharW-1:0] c);
		return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A);
	endfunction

endpackage
`default_nettype wire

// ----- design/numeric_char_reference_decoder.sv -----
// Pipeline: input register, then result register, offered on the master side.
// Throughput: one beat per cycle unless a result waits on a stalled receiver;
//   the decode is one pass from the input register into the result register,
//   with phase and value updated per beat.
// Reset (arst_n low): pipeline empty, phase initial, value zero, stop char 0.
`default_nettype none
module numeric_char_reference_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [20:0] char_code, rest zero
	input  wire logic        s_axis_tuser,   // [0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] code_point, [32] char_consumed
	output logic [1:0]       m_axis_tuser,   // [1:0] status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data
);

	localparam int unsigned CharW = ncrd_pkg::CharW;
	localparam int unsigned AccW  = CharW + 5;

	logic [ncrd_pkg::StopW-1:0] stop_q;

	logic             valid_s1;
	logic             kind_s1;
	logic [CharW-1:0] char_s1;

	ncrd_pkg::phase_t phase_q, phase_d;
	logic [CharW-1:0] acc_q, acc_d;
	logic             inv_q, inv_d;

	logic             out_valid_q;
	ncrd_pkg::status_t out_status_q;
	logic [ncrd_pkg::CodeW-1:0] out_cp_q;
	logic             out_used_q;

	logic             res;
	ncrd_pkg::status_t res_status;
	logic [ncrd_pkg::CodeW-1:0] res_cp;
	logic             res_used;
	logic             out_free;
	logic             done_s1;
	logic             in_fire;

	logic [3:0]       digit;
	logic [AccW-1:0]  acc_x16, acc_x10;
	logic [AccW-1:0]  sum;
	logic             do_add;
	logic             base16;
	logic [ncrd_pkg::CodeW-1:0] cur_cp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= '0;
		end else if (cfg_valid) begin
			stop_q <= cfg_data;
		end
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign done_s1       = !res || out_free;
	assign s_axis_tready = !valid_s1 || done_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= s_axis_tuser;
			char_s1 <= s_axis_tdata[CharW-1:0];
		end
	end

	// digit value: low nibble for 0-9, low nibble + 9 for a-f / A-F
	always_comb begin
		if (ncrd_pkg::is_dec(char_s1)) begin
			digit = char_s1[3:0];
		end else begin
			digit = char_s1[3:0] + 4'd9;
		end
	end

	assign acc_x16 = {acc_q, 4'b0} + AccW'(digit);
	assign acc_x10 = {2'b0, acc_q, 3'b0} + {4'b0, acc_q, 1'b0} + AccW'(digit);
	assign sum     = base16 ? acc_x16 : acc_x10;
	assign cur_cp  = inv_q ? '1 : ncrd_pkg::CodeW'(acc_q);

	always_comb begin
		phase_d    = phase_q;
		res        = 1'b0;
		res_status = ncrd_pkg::ST_NOT_REF;
		res_cp     = '0;
		res_used   = 1'b0;
		do_add     = 1'b0;
		base16     = 1'b0;
		if (kind_s1) begin
			res        = 1'b1;
			res_status = ncrd_pkg::ST_NEED;
		end else begin
			case (phase_q)
				ncrd_pkg::PH_NUMBER: begin
					if (char_s1 == ncrd_pkg::ChX || char_s1 == ncrd_pkg::ChXUp) begin
						phase_d = ncrd_pkg::PH_MAYBE_HEX;
					end else if (ncrd_pkg::is_dec(char_s1)) begin
						phase_d = ncrd_pkg::PH_DECIMAL;
						do_add  = 1'b1;
					end else begin
						res = 1'b1;
					end
				end
				ncrd_pkg::PH_MAYBE_HEX: begin
					if (ncrd_pkg::is_dec(char_s1) || ncrd_pkg::is_hex_alpha(char_s1)) begin
						phase_d = ncrd_pkg::PH_HEX;
						do_add  = 1'b1;
						base16  = 1'b1;
					end else begin
						res = 1'b1;
					end
				end
				ncrd_pkg::PH_HEX: begin
					base16 = 1'b1;
					if (ncrd_pkg::is_dec(char_s1) || ncrd_pkg::is_hex_alpha(char_s1)) begin
						do_add = 1'b1;
					end else begin
						res        = 1'b1;
						res_status = ncrd_pkg::ST_DECODED;
						res_cp     = cur_cp;
						res_used   = char_s1 == ncrd_pkg::ChSemi;
					end
				end
				ncrd_pkg::PH_DECIMAL: begin
					if (ncrd_pkg::is_dec(char_s1)) begin
						do_add = 1'b1;
					end else begin
						res        = 1'b1;
						res_status = ncrd_pkg::ST_DECODED;
						res_cp     = cur_cp;
						res_used   = char_s1 == ncrd_pkg::ChSemi;
					end
				end
				default: begin
					if (char_s1 == ncrd_pkg::ChTab || char_s1 == ncrd_pkg::ChLf ||
					    char_s1 == ncrd_pkg::ChFf || char_s1 == ncrd_pkg::ChSpace ||
					    char_s1 == ncrd_pkg::ChLt || char_s1 == ncrd_pkg::ChAmp) begin
						res = 1'b1;
					end else if (stop_q != '0 && char_s1 == CharW'(stop_q)) begin
						res = 1'b1;
					end else if (char_s1 == ncrd_pkg::ChHash) begin
						phase_d = ncrd_pkg::PH_NUMBER;
					end else if (ncrd_pkg::is_alpha(char_s1)) begin
						res        = 1'b1;
						res_status = ncrd_pkg::ST_NAMED;
					end else begin
						res = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		acc_d = acc_q;
		inv_d = inv_q;
		if (res) begin
			acc_d = '0;
			inv_d = 1'b0;
		end else if (do_add && !inv_q) begin
			if (sum > AccW'(ncrd_pkg::MaxCode)) begin
				inv_d = 1'b1;
			end else begin
				acc_d = sum[CharW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ncrd_pkg::PH_INITIAL;
			acc_q   <= '0;
			inv_q   <= 1'b0;
		end else if (valid_s1 && done_s1) begin
			phase_q <= res ? ncrd_pkg::PH_INITIAL : phase_d;
			acc_q   <= acc_d;
			inv_q   <= inv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && res) begin
			out_status_q <= res_status;
			out_cp_q     <= res_cp;
			out_used_q   <= res_used;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_used_q, out_cp_q};
	assign m_axis_tuser  = out_status_q;

endmodule
`default_nettype wire

// ----- sim/numeric_char_reference_decoder_tb.sv -----
`default_nettype none
module numeric_char_reference_decoder_tb;

	localparam int unsigned CharW = ncrd_pkg::CharW;
	localparam int unsigned CodeW = ncrd_pkg::CodeW;
	localparam int unsigned StopW = ncrd_pkg::StopW;

	localparam logic [CharW-1:0] ChZero  = 21'h30;
	localparam logic [CharW-1:0] ChLowA  = 21'h61;
	localparam logic [CharW-1:0] ChLowF  = 21'h66;
	localparam logic [CharW-1:0] ChLowG  = 21'h67;
	localparam logic [CharW-1:0] ChUpA   = 21'h41;
	localparam logic [CharW-1:0] ChUpF   = 21'h46;
	localparam logic [CharW-1:0] ChUpZ   = 21'h5A;
	localparam logic [CharW-1:0] ChQuot  = 21'h22;
	localparam logic [CharW-1:0] ChApos  = 21'h27;
	localparam logic [CharW-1:0] ChGt    = 21'h3E;
	localparam logic [CharW-1:0] ChNine  = 21'h39;
	localparam logic [CharW-1:0] ChDel   = 21'h7F;
	localparam logic [CodeW-1:0] CodeInvalid = '1;
	localparam logic KindChar = 1'b0;
	localparam logic KindEnd  = 1'b1;
	localparam int DrainCycles = 4;
	localparam int EndCycles   = 8;

	typedef struct {
		ncrd_pkg::status_t status;
		logic [CodeW-1:0]  code_point;
		logic              consumed;
	} ncr_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [20:0] char_code
	logic        s_axis_tuser = 1'b0; // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [31:0] code_point, [32] char_consumed
	logic [1:0]  m_axis_tuser;        // [1:0] status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	ncrd_pkg::phase_t ncr_phase = ncrd_pkg::PH_INITIAL;
	logic [CodeW-1:0] ncr_value = '0;
	logic [StopW-1:0] stop_char = '0;
	ncr_result_t      expected_refs[$];
	ncr_result_t      oldest_ref;

	int  beats_sent = 0;
	int  mismatches = 0;
	int  burst_left = 0;
	bit  bursts_on = 1'b1;
	int  stall_tick = 0;
	int  stall_mode = 0;

	numeric_char_reference_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("numeric_char_reference_decoder regression: fail");
		$finish;
	end

	// receiver stall pattern, with a randomly chosen mode
	always @(negedge clk) begin
		if (stall_tick % 160 == 0) begin
			stall_mode = $urandom_range(0, 3);
		end
		stall_tick++;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (stall_tick % 9) >= 3;
			default: m_axis_tready <= $urandom_range(0, 7) != 0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_refs.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none actual status %0d code %h consumed %b",
					$time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[32]);
			end else begin
				oldest_ref = expected_refs.pop_front();
				if (m_axis_tuser !== oldest_ref.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time,
						oldest_ref.status, m_axis_tuser);
				end
				if (m_axis_tdata[31:0] !== oldest_ref.code_point) begin
					mismatches++;
					$display("%0t: code_point expected %h actual %h", $time,
						oldest_ref.code_point, m_axis_tdata[31:0]);
				end
				if (m_axis_tdata[32] !== oldest_ref.consumed) begin
					mismatches++;
					$display("%0t: char_consumed expected %b actual %b", $time,
						oldest_ref.consumed, m_axis_tdata[32]);
				end
			end
		end
	end

	task automatic finish_ref(input ncrd_pkg::status_t st, input logic [CodeW-1:0] cp,
			input logic used);
		ncr_result_t r;
		r = '{st, cp, used};
		expected_refs.insert(expected_refs.size(), r);
		ncr_phase = ncrd_pkg::PH_INITIAL;
		ncr_value = '0;
	endtask

	task automatic add_digit(input logic [4:0] base, input logic [3:0] d);
		if (ncr_value != CodeInvalid) begin
			ncr_value = ncr_value * base + d;
		end
		if (ncr_value > {11'b0, ncrd_pkg::MaxCode}) begin
			ncr_value = CodeInvalid;
		end
	endtask

	task automatic decode_beat(input logic kind, input logic [CharW-1:0] c);
		logic       dec;
		logic       hexd;
		logic       alpha;
		logic [3:0] dv;
		dec = c >= ChZero && c <= ChNine;
		hexd = dec || (c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF);
		alpha = (c >= ChLowA && c <= 21'h7A) || (c >= ChUpA && c <= ChUpZ);
		if (dec) begin
			dv = 4'(c - ChZero);
		end else if (c >= ChLowA) begin
			dv = 4'(c - ChLowA + 10);
		end else begin
			dv = 4'(c - ChUpA + 10);
		end
		if (kind == KindEnd) begin
			finish_ref(ncrd_pkg::ST_NEED, '0, 1'b0);
		end else begin
			case (ncr_phase)
				ncrd_pkg::PH_NUMBER: begin
					if (c == ncrd_pkg::ChX || c == ncrd_pkg::ChXUp) begin
						ncr_phase = ncrd_pkg::PH_MAYBE_HEX;
					end else if (dec) begin
						ncr_phase = ncrd_pkg::PH_DECIMAL;
						add_digit(5'd10, dv);
					end else begin
						finish_ref(ncrd_pkg::ST_NOT_REF, '0, 1'b0);
					end
				end
				ncrd_pkg::PH_MAYBE_HEX: begin
					if (hexd) begin
						ncr_phase = ncrd_pkg::PH_HEX;
						add_digit(5'd16, dv);
					end else begin
						finish_ref(ncrd_pkg::ST_NOT_REF, '0, 1'b0);
					end
				end
				ncrd_pkg::PH_HEX: begin
					if (hexd) begin
						add_digit(5'd16, dv);
					end else begin
						finish_ref(ncrd_pkg::ST_DECODED, ncr_value, c == ncrd_pkg::ChSemi);
					end
				end
				ncrd_pkg::PH_DECIMAL: begin
					if (dec) begin
						add_digit(5'd10, dv);
					end else begin
						finish_ref(ncrd_pkg::ST_DECODED, ncr_value, c == ncrd_pkg::ChSemi);
					end
				end
				default: begin
					if (c == ncrd_pkg::ChTab || c == ncrd_pkg::ChLf || c == ncrd_pkg::ChFf
							|| c == ncrd_pkg::ChSpace || c == ncrd_pkg::ChLt
							|| c == ncrd_pkg::ChAmp) begin
						finish_ref(ncrd_pkg::ST_NOT_REF, '0, 1'b0);
					end else if (stop_char != '0 && c == {14'b0, stop_char}) begin
						finish_ref(ncrd_pkg::ST_NOT_REF, '0, 1'b0);
					end else if (c == ncrd_pkg::ChHash) begin
						ncr_phase = ncrd_pkg::PH_NUMBER;
						ncr_value = '0;
					end else if (alpha) begin
						finish_ref(ncrd_pkg::ST_NAMED, '0, 1'b0);
					end else begin
						finish_ref(ncrd_pkg::ST_NOT_REF, '0, 1'b0);
					end
				end
			endcase
		end
	endtask

	// called just after a falling edge; returns just after a falling edge, once the beat has been accepted
	task automatic send_beat(input logic kind, input logic [CharW-1:0] c);
		if (bursts_on) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b0, c};
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		decode_beat(kind, c);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_char(input logic [CharW-1:0] c);
		send_beat(KindChar, c);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_refs.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_stop_char(input logic [StopW-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		stop_char = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CharW-1:0] any_char();
		if ($urandom_range(0, 3) == 0) begin
			return CharW'($urandom_range(0, ncrd_pkg::MaxCode));
		end
		return CharW'($urandom_range(0, 127));
	endfunction

	function automatic logic [CharW-1:0] digit_char(input bit hexmode);
		int d;
		d = hexmode ? $urandom_range(0, 15) : $urandom_range(0, 9);
		if (d < 10) begin
			return ChZero + CharW'(d);
		end
		return ($urandom_range(0, 1) ? ChUpA : ChLowA) + CharW'(d - 10);
	endfunction

	function automatic logic [CharW-1:0] start_char();
		case ($urandom_range(0, 10))
			0: return ncrd_pkg::ChTab;
			1: return ncrd_pkg::ChLf;
			2: return ncrd_pkg::ChFf;
			3: return ncrd_pkg::ChSpace;
			4: return ncrd_pkg::ChLt;
			5: return ncrd_pkg::ChAmp;
			6: return {14'b0, stop_char};
			7: return ChQuot;
			8: return ChApos;
			9: return $urandom_range(0, 1) ? CharW'($urandom_range(ChLowA, 21'h7A))
				: CharW'($urandom_range(ChUpA, ChUpZ));
			default: return any_char();
		endcase
	endfunction

	task automatic random_reference();
		int  pick;
		int  n;
		bit  hexmode;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			send_char(ncrd_pkg::ChHash);
			hexmode = 1'($urandom_range(0, 1));
			if (hexmode) begin
				send_char($urandom_range(0, 1) ? ncrd_pkg::ChX : ncrd_pkg::ChXUp);
			end
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 9);
			repeat (n) send_char(digit_char(hexmode));
			n = $urandom_range(0, 9);
			if (n < 6) begin
				send_char(ncrd_pkg::ChSemi);
			end else if (n < 8) begin
				send_char(any_char());
			end else begin
				send_beat(KindEnd, any_char());
			end
		end else if (pick < 75) begin
			send_char(start_char());
		end else if (pick < 90) begin
			send_char(ncrd_pkg::ChHash);
			case ($urandom_range(0, 3))
				0: send_char($urandom_range(0, 1) ? ncrd_pkg::ChSemi : any_char());
				1: begin
					send_char(ncrd_pkg::ChX);
					send_char($urandom_range(0, 1) ? ChLowG : any_char());
				end
				2: begin
					send_char(ncrd_pkg::ChXUp);
					send_beat(KindEnd, any_char());
				end
				default: begin
					send_char(digit_char(1'b0));
					send_beat(KindEnd, any_char());
				end
			endcase
		end else begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 9) == 0) begin
					send_beat(KindEnd, any_char());
				end else begin
					send_char(any_char());
				end
			end
		end
	endtask

	task automatic test_directed();
		send_char(ncrd_pkg::ChTab);
		send_char(ncrd_pkg::MaxCode);
		send_char(ChLowA);
		send_char(ChUpZ);
		send_char(ncrd_pkg::ChHash);
		send_char(ncrd_pkg::ChX);
		send_char(ChUpF);
		send_char(ChLowF);
		send_char(ncrd_pkg::ChSemi);
		send_char(ncrd_pkg::ChHash);
		send_char(ChNine);
		send_char('0);
		send_char(ncrd_pkg::ChHash);
		send_char(ncrd_pkg::ChSemi);
		send_char(ncrd_pkg::ChHash);
		send_char(ncrd_pkg::ChXUp);
		send_char(ChLowG);
		send_char(ncrd_pkg::ChHash);
		send_char(ncrd_pkg::ChX);
		send_beat(KindEnd, ncrd_pkg::MaxCode);
		send_beat(KindEnd, '0);
	endtask

	task automatic test_stop_char();
		write_stop_char(ncrd_pkg::ChHash[6:0]);
		send_char(ncrd_pkg::ChHash);
		send_char(ChLowA);
		write_stop_char(ChDel[6:0]);
		send_char(ChDel);
	endtask

	task automatic test_random(input logic [StopW-1:0] stop, input int count, input bit gaps);
		int target;
		write_stop_char(stop);
		bursts_on = gaps;
		burst_left = 0;
		target = beats_sent + count;
		while (beats_sent < target) random_reference();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_stop_char();
		test_random(7'h00, 100, 1'b1);
		test_random(ChQuot[6:0], 100, 1'b1);
		test_random(ChDel[6:0], 90, 1'b0);
		test_random(ncrd_pkg::ChHash[6:0], 55, 1'b1);
		test_random(7'($urandom_range(0, 127)), 100, 1'b1);
		test_random(ChLowA[6:0], 70, 1'b1);
		test_random(ChGt[6:0], 70, 1'b1);
		s_axis_tvalid <= 1'b0;
		while (expected_refs.size() != 0) @(negedge clk);
		repeat (EndCycles) @(negedge clk);
		if (mismatches == 0 && expected_refs.size() == 0) begin
			$display("numeric_char_reference_decoder regression: pass");
		end else begin
			$display("numeric_char_reference_decoder regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
